/* src/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// implication checked at every clock edge out of reset
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* src/wms_pkg.sv */
// shared types and constants for the window mean and deviation block
package wms_pkg;
	localparam int FRAC_W          = 16;
	localparam int MAX_COUNT_DEF   = 1024;
	localparam int SAMPLE_BITS_DEF = 16;

	typedef logic [FRAC_W-1:0] frac_t;
endpackage

/* src/wms_if.sv */
// valid/ready channel interfaces for samples and results
interface wms_in_if;
	import wms_pkg::*;

	logic  valid;
	logic  ready;
	frac_t fraction_sample;
	logic  window_end;

	modport source (output valid, output fraction_sample, output window_end, input ready);
	modport sink (input valid, input fraction_sample, input window_end, output ready);
endinterface

interface wms_out_if;
	import wms_pkg::*;

	logic  valid;
	logic  ready;
	frac_t std_dev;
	frac_t mean_value;
	logic  count_overflow;

	modport source (output valid, output std_dev, output mean_value, output count_overflow,
		input ready);
	modport sink (input valid, input std_dev, input mean_value, input count_overflow,
		output ready);
endinterface

/* src/window_mean_stddev.sv */
// window mean and population standard deviation, bit-serial finish
//
//  channel   dir  payload                                      transaction
//  samples   in   fraction_sample[15:0], window_end            valid & ready
//  results   out  std_dev[15:0], mean_value[15:0], count_overflow  valid & ready
//
// one sample per cycle while a window accumulates and no window end waits
// (one square per cycle). a window end starts a bit-serial finish: S1W
// multiply steps, a difference step, RW square-root steps, DVW divide steps
// and a hand-off step into the output register.
// a second window end waits in the input stage until the finish is done.
// the result waits in an output register; arst_n clears all control state.
`include "assert_macros.svh"

module window_mean_stddev #(
	parameter int MAX_COUNT   = wms_pkg::MAX_COUNT_DEF,
	parameter int SAMPLE_BITS = wms_pkg::SAMPLE_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	wms_in_if.sink          samples,
	wms_out_if.source       results
);
	import wms_pkg::*;

	localparam int SW    = (SAMPLE_BITS < FRAC_W) ? SAMPLE_BITS : FRAC_W;
	localparam int CW    = $clog2(MAX_COUNT + 1);
	localparam int S1W   = SW + CW;
	localparam int S2W   = 2 * SW + CW;
	localparam int DW    = (2 * S1W < 64) ? 2 * S1W : 64;
	localparam int RW    = (DW + 1) / 2;
	localparam int RADW  = 2 * RW;
	localparam int DVW   = (S1W > RW) ? S1W : RW;
	localparam int STEPW = $clog2(DVW + 1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_DIFF = 6'b000100,
		ST_SQRT = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_HOLD = 6'b100000
	} state_t;

	// input stage
	logic            v_s1;
	logic            last_s1;
	logic [SW-1:0]   smp_s1;
	logic [2*SW-1:0] sq_s1;

	// accumulators
	logic [S1W-1:0] sum_q;
	logic [S2W-1:0] sumsq_q;
	logic [CW-1:0]  count_q;
	logic           ovf_q;

	logic [S1W-1:0] sum_nx;
	logic [S2W-1:0] sumsq_nx;
	logic [CW-1:0]  count_nx;
	logic [CW-1:0]  n_launch;
	logic           ovf_nx;
	logic           take;
	logic           stall_s1;
	logic           acc_en;
	logic           launch;

	// finish datapath
	state_t          state_q;
	logic [STEPW-1:0] step_q;
	logic [S1W-1:0]  s1_w_q;
	logic [S2W-1:0]  s2_w_q;
	logic [CW-1:0]   n_q;
	logic            ovf_w_q;
	logic [S1W-1:0]  n_sh_q;
	logic [S1W-1:0]  s1_sh_q;
	logic [DW-1:0]   acc_p_q;
	logic [DW-1:0]   acc_q_q;
	logic [RADW-1:0] rad_q;
	logic [RW+1:0]   rem_q;
	logic [RW-1:0]   root_q;
	logic [DVW-1:0]  qa_q;
	logic [DVW-1:0]  qb_q;
	logic [CW-1:0]   ra_q;
	logic [CW-1:0]   rb_q;

	logic [RW+1:0]   rem_sh;
	logic [RW+1:0]   trial;
	logic            root_ge;
	logic [RW+1:0]   rem_nx;
	logic [RW-1:0]   root_nx;
	logic [CW:0]     ra_sh;
	logic [CW:0]     rb_sh;
	logic            qa_ge;
	logic            qb_ge;
	logic            step_done;
	logic            hand_off;

	// output register
	logic  out_valid_q;
	frac_t std_q;
	frac_t mean_q;
	logic  ovf_out_q;

	assign stall_s1      = v_s1 && last_s1 && (state_q != ST_IDLE);
	assign samples.ready = !stall_s1;
	assign acc_en        = v_s1 && !stall_s1;
	assign launch        = acc_en && last_s1;

	assign take     = count_q < CW'(MAX_COUNT);
	assign sum_nx   = take ? sum_q + S1W'(smp_s1) : sum_q;
	assign sumsq_nx = take ? sumsq_q + S2W'(sq_s1) : sumsq_q;
	assign count_nx = take ? count_q + CW'(1) : count_q;
	assign n_launch = (count_nx == '0) ? CW'(1) : count_nx;
	assign ovf_nx   = ovf_q || !take;

	assign step_done = (step_q == '0);
	assign hand_off  = (state_q == ST_HOLD) && (!out_valid_q || results.ready);

	// square root step
	always_comb begin
		rem_sh  = {rem_q[RW-1:0], rad_q[RADW-1 -: 2]};
		trial   = {root_q, 2'b01};
		root_ge = rem_sh >= trial;
		rem_nx  = root_ge ? rem_sh - trial : rem_sh;
		root_nx = {root_q[RW-2:0], root_ge};
	end

	// restoring divide steps, both quotients share the divisor
	always_comb begin
		ra_sh = {ra_q, qa_q[DVW-1]};
		rb_sh = {rb_q, qb_q[DVW-1]};
		qa_ge = ra_sh >= {1'b0, n_q};
		qb_ge = rb_sh >= {1'b0, n_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (samples.valid && samples.ready) begin
			v_s1 <= 1'b1;
		end else if (acc_en) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			smp_s1  <= samples.fraction_sample[SW-1:0];
			sq_s1   <= (2*SW)'(samples.fraction_sample[SW-1:0]) *
				(2*SW)'(samples.fraction_sample[SW-1:0]);
			last_s1 <= samples.window_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			sumsq_q <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (acc_en) begin
			if (last_s1) begin
				sum_q   <= '0;
				sumsq_q <= '0;
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				sum_q   <= sum_nx;
				sumsq_q <= sumsq_nx;
				count_q <= count_nx;
				ovf_q   <= ovf_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (launch) begin
						state_q <= ST_MUL;
						step_q  <= STEPW'(S1W - 1);
					end
				end
				ST_MUL: begin
					if (step_done) begin
						state_q <= ST_DIFF;
					end else begin
						step_q <= step_q - STEPW'(1);
					end
				end
				ST_DIFF: begin
					state_q <= ST_SQRT;
					step_q  <= STEPW'(RW - 1);
				end
				ST_SQRT: begin
					if (step_done) begin
						state_q <= ST_DIV;
						step_q  <= STEPW'(DVW - 1);
					end else begin
						step_q <= step_q - STEPW'(1);
					end
				end
				ST_DIV: begin
					if (step_done) begin
						state_q <= ST_HOLD;
					end else begin
						step_q <= step_q - STEPW'(1);
					end
				end
				ST_HOLD: begin
					if (hand_off) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (launch) begin
					s1_w_q  <= sum_nx;
					s2_w_q  <= sumsq_nx;
					n_q     <= n_launch;
					ovf_w_q <= ovf_nx;
					n_sh_q  <= S1W'(n_launch);
					s1_sh_q <= sum_nx;
					acc_p_q <= '0;
					acc_q_q <= '0;
				end
			end
			ST_MUL: begin
				acc_p_q <= (acc_p_q << 1) + (n_sh_q[S1W-1] ? DW'(s2_w_q) : DW'(0));
				acc_q_q <= (acc_q_q << 1) + (s1_sh_q[S1W-1] ? DW'(s1_w_q) : DW'(0));
				n_sh_q  <= n_sh_q << 1;
				s1_sh_q <= s1_sh_q << 1;
			end
			ST_DIFF: begin
				rad_q  <= (acc_p_q < acc_q_q) ? '0 : RADW'(acc_p_q - acc_q_q);
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_SQRT: begin
				rad_q  <= rad_q << 2;
				rem_q  <= rem_nx;
				root_q <= root_nx;
				if (step_done) begin
					qa_q <= DVW'(s1_w_q);
					qb_q <= DVW'(root_nx);
					ra_q <= '0;
					rb_q <= '0;
				end
			end
			ST_DIV: begin
				ra_q <= qa_ge ? CW'(ra_sh - {1'b0, n_q}) : CW'(ra_sh);
				rb_q <= qb_ge ? CW'(rb_sh - {1'b0, n_q}) : CW'(rb_sh);
				qa_q <= {qa_q[DVW-2:0], qa_ge};
				qb_q <= {qb_q[DVW-2:0], qb_ge};
			end
			ST_HOLD: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (hand_off) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hand_off) begin
			std_q     <= FRAC_W'(qb_q);
			mean_q    <= FRAC_W'(qa_q);
			ovf_out_q <= ovf_w_q;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.std_dev        = std_q;
	assign results.mean_value     = mean_q;
	assign results.count_overflow = ovf_out_q;

	`ASSERT_ALWAYS(a_count_bound, count_q <= CW'(MAX_COUNT), "sample count beyond limit")
	`ASSERT_IMPLY(a_result_from_hold, $rose(out_valid_q), $past(state_q == ST_HOLD), "result loaded outside hand-off")
	`ASSERT_IMPLY(a_start_on_end, $past(state_q == ST_IDLE) && (state_q != ST_IDLE), $past(v_s1 && last_s1), "finish started without window end")
	`ASSERT_IMPLY(a_end_waits, v_s1 && last_s1 && (state_q != ST_IDLE), !samples.ready, "transaction taken over a waiting window end")
endmodule

/* test/window_mean_stddev_tb.sv */
// testbench for window_mean_stddev: random windows checked against an exact-sum predictor
module window_mean_stddev_tb;
	import wms_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_COUNT   = MAX_COUNT_DEF;
	localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
	localparam int TOTAL_ITEMS  = 2000;
	localparam int CALM_ITEMS   = 300;
	localparam int DRAIN_CYCLES = 150;

	typedef struct packed {
		frac_t std_dev;
		frac_t mean_value;
		logic  count_overflow;
	} window_stats_t;

	class window_stats_board;
		longint unsigned sum_s;
		longint unsigned sum_sq;
		int unsigned     count;
		bit              overflow;
		window_stats_t   expected_stats[$];
		int unsigned     mismatches;

		function new();
			sum_s      = 0;
			sum_sq     = 0;
			count      = 0;
			overflow   = 0;
			mismatches = 0;
		endfunction

		function longint unsigned floor_root(longint unsigned v);
			longint unsigned r = 0;
			longint unsigned b = 64'h4000_0000_0000_0000;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function void note_sample(frac_t sample, logic last);
			longint unsigned s;
			longint unsigned n;
			longint unsigned sq1;
			longint unsigned prod;
			window_stats_t   st;
			s = longint'(sample) & ((64'd1 << SAMPLE_BITS) - 1);
			if (count >= MAX_COUNT) begin
				overflow = 1;
			end else begin
				sum_s  += s;
				sum_sq += s * s;
				count++;
			end
			if (last) begin
				n = (count == 0) ? 1 : count;
				sq1  = sum_s * sum_s;
				prod = n * sum_sq;
				st.mean_value     = frac_t'(sum_s / n);
				st.std_dev        = frac_t'(floor_root((prod < sq1) ? 0 : prod - sq1) / n);
				st.count_overflow = overflow;
				expected_stats = {expected_stats, st};
				sum_s    = 0;
				sum_sq   = 0;
				count    = 0;
				overflow = 0;
			end
		endfunction

		function void check_stats(frac_t sd, frac_t mean, logic ovf);
			window_stats_t st;
			if (expected_stats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: std_dev=%0d mean_value=%0d count_overflow=%0b",
						sd, mean, ovf);
				return;
			end
			st = expected_stats.pop_front();
			if (sd !== st.std_dev || mean !== st.mean_value || ovf !== st.count_overflow) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: std_dev exp %0d got %0d, mean_value exp %0d got %0d, %s%0b got %0b",
						st.std_dev, sd, st.mean_value, mean, "count_overflow exp ",
						st.count_overflow, ovf);
			end
		endfunction

		function int pending();
			return expected_stats.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   calm;
	int   sent;

	wms_in_if  samples_ch ();
	wms_out_if results_ch ();

	window_stats_board board;

	window_mean_stddev dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.results (results_ch)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	task automatic send_sample(frac_t sample, logic last);
		samples_ch.valid           <= 1'b1;
		samples_ch.fraction_sample <= sample;
		samples_ch.window_end      <= last;
		do
			@(posedge clk);
		while (!samples_ch.ready);
		board.note_sample(sample, last);
		sent++;
		if (!calm && $urandom_range(0, 7) == 0) begin
			samples_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	task automatic send_window(int len, int shape);
		frac_t v;
		frac_t base;
		base = frac_t'($urandom);
		for (int i = 0; i < len; i++) begin
			unique case (shape)
				0: v = frac_t'($urandom);
				1: v = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
				2: v = base;
				3: v = base ^ frac_t'($urandom_range(0, 255));
				default: v = frac_t'($urandom_range(0, 255)) | (frac_t'($urandom_range(0, 1)) << 15);
			endcase
			send_sample(v, i == len - 1);
		end
	endtask

	task automatic drain_results();
		samples_ch.valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	// sink side: random stall bursts, none in the final stretch
	initial begin
		int stall_left;
		stall_left = 0;
		results_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (results_ch.valid && results_ch.ready)
				board.check_stats(results_ch.std_dev, results_ch.mean_value,
					results_ch.count_overflow);
			if (stall_left > 0) begin
				stall_left--;
				results_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 16) - 1;
				results_ch.ready <= 1'b0;
			end else begin
				results_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int len;
		board = new();
		calm  = 0;
		sent  = 0;
		arst_n = 1'b0;
		samples_ch.valid           = 1'b0;
		samples_ch.fraction_sample = '0;
		samples_ch.window_end      = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single sample windows at both extremes
		send_sample(16'h0000, 1'b1);
		send_sample(16'hFFFF, 1'b1);
		// widest spread
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'h0000, 1'b1);
		send_sample(16'h0000, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'h0000, 1'b0);
		send_sample(16'hFFFF, 1'b1);
		// constant window
		repeat (2) send_sample(16'd12345, 1'b0);
		send_sample(16'd12345, 1'b1);
		for (int i = 1; i <= 8; i++)
			send_sample(frac_t'(i), i == 8);
		send_sample(16'hAAAA, 1'b0);
		send_sample(16'h5555, 1'b1);

		drain_results();
		@(posedge clk);

		// window one sample too long, the window end itself is dropped
		send_window(MAX_COUNT + 1, 1);

		while (sent < TOTAL_ITEMS) begin
			calm = (sent >= TOTAL_ITEMS - CALM_ITEMS);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
			send_window(len, $urandom_range(0, 4));
		end
		calm = 1;

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end
endmodule
